### rtl/tap_pkg.sv
// Package: widths, constants and types shared by the triangle area/perimeter block
`timescale 1ns / 1ps
`default_nettype none
package tap_pkg;
  localparam int FRAC_BITS  = 4;
  localparam int COORD_W    = 13;
  localparam int REG_W      = 12;
  localparam int PERIM_W    = 19;
  localparam int AREA_W     = 25;
  // squared distance: 2 * 4095^2 < 2^25, scaled by 2^(2*FRAC_BITS)
  localparam int SQ_W       = 25;
  localparam int RAD_W      = SQ_W + 2 * FRAC_BITS;
  localparam int ROOT_W     = (RAD_W + 1) / 2;
  localparam int NCELL      = ROOT_W;
  // working width of a root cell's trial subtract
  localparam int TRIAL_W    = RAD_W + 2;
  // valid bits: clamp, products, radicand load, then one per root cell
  localparam int PIPE_DEPTH = NCELL + 3;
  localparam int CROSS_W    = 26;
  localparam logic [PERIM_W-1:0] PERIM_MAX = '1;
  localparam logic [REG_W-1:0] MAX_X_RST = 12'd639;
  localparam logic [REG_W-1:0] MAX_Y_RST = 12'd399;
  localparam logic REG_MAX_X = 1'b0;
  localparam logic REG_MAX_Y = 1'b1;

  typedef struct packed {
    logic [REG_W-1:0] a_x;
    logic [REG_W-1:0] a_y;
    logic [REG_W-1:0] b_x;
    logic [REG_W-1:0] b_y;
    logic [REG_W-1:0] c_x;
    logic [REG_W-1:0] c_y;
  } pts_t;

  // one root-extraction lane state, three sides at once
  typedef struct packed {
    logic [2:0][RAD_W-1:0]  rem;
    logic [2:0][ROOT_W-1:0] root;
    logic [AREA_W-1:0]      area;
  } cell_t;
endpackage
`default_nettype wire

### rtl/tap_if.sv
// Interfaces: valid/ready stream channels and configuration write channel
`timescale 1ns / 1ps
`default_nettype none
interface tap_in_if;
  logic valid;
  logic ready;
  logic signed [12:0] a_x, a_y, b_x, b_y, c_x, c_y;
  modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, input ready);
  modport sink (input valid, a_x, a_y, b_x, b_y, c_x, c_y, output ready);
endinterface

interface tap_out_if;
  logic valid;
  logic ready;
  logic [18:0] perimeter_q4;
  logic [24:0] double_area;
  modport source (output valid, perimeter_q4, double_area, input ready);
  modport sink (input valid, perimeter_q4, double_area, output ready);
endinterface

interface tap_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/tap_front.sv
// Front stage: edge deltas, squared lengths and cross product
`timescale 1ns / 1ps
`default_nettype none
module tap_front (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire tap_pkg::pts_t       pts,
  output tap_pkg::cell_t           lane
);
  logic signed [12:0] d1x, d1y, d2x, d2y, d3x, d3y;
  logic [23:0] s1x, s1y, s2x, s2y, s3x, s3y;
  logic signed [25:0] m1, m2;
  logic [24:0] q1, q2, q3;
  logic signed [tap_pkg::CROSS_W-1:0] cr;

  // deltas (stage A result)
  always_comb begin
    d1x = $signed({1'b0, pts.b_x}) - $signed({1'b0, pts.a_x});
    d1y = $signed({1'b0, pts.b_y}) - $signed({1'b0, pts.a_y});
    d2x = $signed({1'b0, pts.c_x}) - $signed({1'b0, pts.b_x});
    d2y = $signed({1'b0, pts.c_y}) - $signed({1'b0, pts.b_y});
    d3x = $signed({1'b0, pts.c_x}) - $signed({1'b0, pts.a_x});
    d3y = $signed({1'b0, pts.c_y}) - $signed({1'b0, pts.a_y});
  end

  // products registered, then summed
  always_ff @(posedge clk) begin
    if (en) begin
      s1x <= 24'(d1x * d1x);
      s1y <= 24'(d1y * d1y);
      s2x <= 24'(d2x * d2x);
      s2y <= 24'(d2y * d2y);
      s3x <= 24'(d3x * d3x);
      s3y <= 24'(d3y * d3y);
      m1  <= 26'(d1x * d3y);
      m2  <= 26'(d3x * d1y);
    end
  end

  always_comb begin
    q1 = {1'b0, s1x} + {1'b0, s1y};
    q2 = {1'b0, s2x} + {1'b0, s2y};
    q3 = {1'b0, s3x} + {1'b0, s3y};
    cr = m1 - m2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane.rem[0]  <= {q1, {(2 * tap_pkg::FRAC_BITS){1'b0}}};
      lane.rem[1]  <= {q2, {(2 * tap_pkg::FRAC_BITS){1'b0}}};
      lane.rem[2]  <= {q3, {(2 * tap_pkg::FRAC_BITS){1'b0}}};
      lane.root    <= '0;
      lane.area    <= tap_pkg::AREA_W'(cr[tap_pkg::CROSS_W-1] ? -cr : cr);
    end
  end
endmodule
`default_nettype wire

### rtl/tap_cell.sv
// Root cell: one restoring square-root bit for each of the three sides
`timescale 1ns / 1ps
`default_nettype none
module tap_cell (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [4:0]    step,
  input  wire tap_pkg::cell_t din,
  output tap_pkg::cell_t     dout
);
  tap_pkg::cell_t nxt;
  logic [5:0] sh;
  logic [tap_pkg::TRIAL_W-1:0] trial [3];
  logic [tap_pkg::TRIAL_W-1:0] top [3];

  // bit weight of this cell, fixed by its place in the chain
  always_comb begin
    sh = 6'(2 * (tap_pkg::ROOT_W - 1 - int'(step)));
  end

  // trial subtract of (4*root+1) at this bit weight
  always_comb begin
    nxt = din;
    for (int i = 0; i < 3; i++) begin
      top[i]   = tap_pkg::TRIAL_W'(din.rem[i]) >> sh;
      trial[i] = (tap_pkg::TRIAL_W'(din.root[i]) << 2) | tap_pkg::TRIAL_W'(1);
      if (top[i] >= trial[i]) begin
        nxt.rem[i]  = tap_pkg::RAD_W'(tap_pkg::TRIAL_W'(din.rem[i]) - (trial[i] << sh));
        nxt.root[i] = tap_pkg::ROOT_W'({din.root[i], 1'b1});
      end else begin
        nxt.root[i] = tap_pkg::ROOT_W'({din.root[i], 1'b0});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/triangle_area_perimeter_top.sv
// Top level: config registers, front stage, chain of root cells, output stage
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 21 register stages (3 front stages, 17 root cells, 1 output register).
// Throughput: one triangle per cycle while the output is not stalled; set by the chain of root cells, one bit per cell.
// The whole pipe advances when the output register is empty or being taken.
// Reset: pipe valid bits clear, max_x = 639, max_y = 399. Config channel always ready.
module triangle_area_perimeter_top (
  input wire logic clk,
  input wire logic rst,
  tap_in_if.sink   in_ch,
  tap_out_if.source out_ch,
  tap_cfg_if.sink  cfg
);
  logic [tap_pkg::REG_W-1:0] max_x, max_y;
  logic [tap_pkg::PIPE_DEPTH-1:0] vld;
  logic en;
  tap_pkg::pts_t pts;
  tap_pkg::cell_t chain [tap_pkg::NCELL+1];
  logic [tap_pkg::ROOT_W+1:0] psum;

  // config registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_x <= tap_pkg::MAX_X_RST;
      max_y <= tap_pkg::MAX_Y_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        tap_pkg::REG_MAX_X: max_x <= cfg.data;
        tap_pkg::REG_MAX_Y: max_y <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipe advance
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[tap_pkg::PIPE_DEPTH-2:0], in_ch.valid};
    end
  end

  function automatic logic [11:0] clamp(logic signed [12:0] v, logic [11:0] b);
    if (v[12]) return '0;
    if (v[11:0] > b) return b;
    return v[11:0];
  endfunction

  // clamp stage
  always_ff @(posedge clk) begin
    if (en) begin
      pts.a_x <= clamp(in_ch.a_x, max_x);
      pts.a_y <= clamp(in_ch.a_y, max_y);
      pts.b_x <= clamp(in_ch.b_x, max_x);
      pts.b_y <= clamp(in_ch.b_y, max_y);
      pts.c_x <= clamp(in_ch.c_x, max_x);
      pts.c_y <= clamp(in_ch.c_y, max_y);
    end
  end

  tap_front u_front (.clk(clk), .en(en), .pts(pts), .lane(chain[0]));

  for (genvar g = 0; g < tap_pkg::NCELL; g++) begin : g_cell
    tap_cell u_cell (
      .clk(clk), .en(en), .step(5'(g)), .din(chain[g]), .dout(chain[g+1])
    );
  end

  // perimeter sum and saturation into output register
  assign psum = {2'b0, chain[tap_pkg::NCELL].root[0]}
              + {2'b0, chain[tap_pkg::NCELL].root[1]}
              + {2'b0, chain[tap_pkg::NCELL].root[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= vld[tap_pkg::PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.perimeter_q4 <= (psum > (tap_pkg::ROOT_W+2)'(tap_pkg::PERIM_MAX))
                             ? tap_pkg::PERIM_MAX : tap_pkg::PERIM_W'(psum);
      out_ch.double_area  <= chain[tap_pkg::NCELL].area;
    end
  end
endmodule
`default_nettype wire

### rtl/tap_checker.sv
// Port checker for the triangle area/perimeter block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module tap_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [18:0] perimeter_q4,
  input wire logic [24:0] double_area
);
  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(perimeter_q4) && $stable(double_area))
    else $error("result changed while stalled");
  // input is taken whenever output is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input blocked with empty output");
  // stalled output blocks input
  a_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("input taken while stalled");
  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) $fell(rst) |-> !out_valid)
    else $error("result after reset");
endmodule

bind triangle_area_perimeter_top tap_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .perimeter_q4(out_ch.perimeter_q4), .double_area(out_ch.double_area)
);
`default_nettype wire
